>>> rtl/bsort_pkg.sv
// shared types and constants for the byte sequence sorter
package bsort_pkg;

  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  // sorter phases
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/bsort_cell.sv
// one slot of the sorted insertion chain
module bsort_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bsort_pkg::cell_ctrl_t ctrl,
  input  bsort_pkg::byte_t    ins_byte,
  input  logic                left_gt,
  input  bsort_pkg::byte_t    left_data,
  input  logic                left_valid,
  input  bsort_pkg::byte_t    right_data,
  input  logic                right_valid,
  output bsort_pkg::byte_t    data,
  output logic                valid,
  output logic                gt
);
  import bsort_pkg::*;

  byte_t data_r;
  byte_t data_nxt;
  logic  valid_r;
  logic  valid_nxt;

  // an empty slot counts as larger than any byte
  assign gt = !valid_r || (data_r > ins_byte);

  // insert: larger entries move up one slot; drain: entries move down one slot
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.insert && gt) begin
      if (left_gt) begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end else begin
        data_nxt  = ins_byte;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.shift) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stored byte
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

>>> rtl/byte_sequence_sorter.sv
// top level: streaming byte sorter built from a chain of insertion cells
//
//  channel  handshake            payload
//  input    start & !busy        in_data_byte, in_is_last
//  result   out_valid (strobe)   out_sorted_byte, out_end_of_run, out_overflowed
//
// each input byte is placed in the chain in the cycle it is accepted, one per cycle
// while busy is low; a byte taken while the chain is full is dropped instead. after
// the transaction with in_is_last, the run drains one byte per cycle from cell 0.
// busy is high while draining; a new run starts the cycle after end_of_run.
// reset (synchronous, rst_n low) empties the chain; results cannot be stalled.
module byte_sequence_sorter #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsort_pkg::byte_t  in_data_byte,
  input  logic              in_is_last,
  output logic              out_valid,
  output bsort_pkg::byte_t  out_sorted_byte,
  output logic              out_end_of_run,
  output logic              out_overflowed
);
  import bsort_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic       overflow_r;
  logic       overflow_nxt;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;

  byte_t cell_data  [MAX_LEN];
  logic  cell_valid [MAX_LEN];
  logic  cell_gt    [MAX_LEN];

  assign accept = start && (state_r == ST_FILL);
  assign full   = cell_valid[MAX_LEN-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL:  if (accept && in_is_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!cell_valid[1]) state_nxt = ST_FILL;
      default:  state_nxt = ST_FILL;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    ctrl.insert    = 1'b0;
    ctrl.shift     = 1'b0;
    busy           = 1'b0;
    out_valid      = 1'b0;
    out_end_of_run = 1'b0;
    overflow_nxt   = overflow_r;
    case (state_r)
      ST_FILL: begin
        if (accept) begin
          if (full) begin
            overflow_nxt = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        busy           = 1'b1;
        out_valid      = cell_valid[0];
        out_end_of_run = !cell_valid[1];
        ctrl.shift     = 1'b1;
        if (!cell_valid[1]) overflow_nxt = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_sorted_byte = cell_data[0];
  assign out_overflowed  = overflow_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // insertion chain
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic  left_gt;
    byte_t left_data;
    logic  left_valid;
    byte_t right_data;
    logic  right_valid;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_data  = '0;
      assign left_valid = 1'b0;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    bsort_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .ins_byte    (in_data_byte),
      .left_gt     (left_gt),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

endmodule

>>> sim/byte_sequence_sorter_test.sv
// self-checking testbench for the streaming byte sequence sorter
`timescale 1ns / 100ps

module byte_sequence_sorter_test;

  import bsort_pkg::*;

  localparam int unsigned SORT_DEPTH = 64;

  // one sorted byte as the block should emit it
  typedef struct {
    byte_t sorted_byte;
    logic  end_of_run;
    logic  overflowed;
  } sorted_out_t;

  // tracks the run in progress and holds the sorted bytes still owed by the block
  class sort_checker;
    byte_t       held_bytes[SORT_DEPTH];
    int unsigned fill_count;
    bit          overflow_seen;
    sorted_out_t owed_bytes[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned runs_done;
    int unsigned overflow_runs;

    function new();
      fill_count    = 0;
      overflow_seen = 0;
      errors        = 0;
      checked       = 0;
      runs_done     = 0;
      overflow_runs = 0;
    endfunction

    // insert one accepted byte, and on the last byte queue the whole sorted run
    function void note_byte(byte_t value, logic last);
      int unsigned pos;
      sorted_out_t item;
      if (fill_count < SORT_DEPTH) begin
        pos = fill_count;
        // larger entries move up, equal entries keep arrival order
        while (pos > 0 && held_bytes[pos-1] > value) begin
          held_bytes[pos] = held_bytes[pos-1];
          pos--;
        end
        held_bytes[pos] = value;
        fill_count++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (last) begin
        for (int unsigned k = 0; k < fill_count; k++) begin
          item.sorted_byte = held_bytes[k];
          item.end_of_run  = (k + 1 == fill_count);
          item.overflowed  = overflow_seen;
          owed_bytes.push_back(item);
        end
        runs_done++;
        if (overflow_seen) overflow_runs++;
        fill_count    = 0;
        overflow_seen = 1'b0;
      end
    endfunction

    // compare one emitted byte against the oldest owed one
    function void check_output(byte_t sorted_byte, logic end_of_run, logic overflowed);
      sorted_out_t want;
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected result byte=%02h end_of_run=%b overflowed=%b",
                 $time, sorted_byte, end_of_run, overflowed);
        errors++;
        return;
      end
      want = owed_bytes.pop_front();
      checked++;
      if (sorted_byte !== want.sorted_byte) begin
        $display("%0t: sorted_byte mismatch expected %02h actual %02h",
                 $time, want.sorted_byte, sorted_byte);
        errors++;
      end
      if (end_of_run !== want.end_of_run) begin
        $display("%0t: end_of_run mismatch expected %b actual %b",
                 $time, want.end_of_run, end_of_run);
        errors++;
      end
      if (overflowed !== want.overflowed) begin
        $display("%0t: overflowed mismatch expected %b actual %b",
                 $time, want.overflowed, overflowed);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  byte_t in_data_byte;
  logic  in_is_last;
  logic  out_valid;
  byte_t out_sorted_byte;
  logic  out_end_of_run;
  logic  out_overflowed;

  sort_checker sorter_sb;
  int unsigned bytes_sent;
  int unsigned burst_left;
  bit          no_gaps;

  byte_sequence_sorter #(
    .MAX_LEN(SORT_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data_byte   (in_data_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_sorted_byte(out_sorted_byte),
    .out_end_of_run (out_end_of_run),
    .out_overflowed (out_overflowed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // monitor: check results first, then note the accepted input transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sorter_sb.check_output(out_sorted_byte, out_end_of_run, out_overflowed);
      if (start && !busy)
        sorter_sb.note_byte(in_data_byte, in_is_last);
    end
  end

  // idle cycles with noise on the payload
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      in_data_byte <= byte_t'($urandom);
      in_is_last   <= 1'($urandom);
    end
  endtask

  // present one byte and hold it until the block takes it
  task automatic drive_byte(input byte_t value, input logic last);
    @(negedge clk);
    start        <= 1'b1;
    in_data_byte <= value;
    in_is_last   <= last;
    do @(posedge clk); while (busy);
    bytes_sent++;
  endtask

  // sender burst pacing
  task automatic pace_sender();
    if (burst_left == 0) begin
      if (!no_gaps) idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_list(input byte_t vals[$]);
    foreach (vals[i]) drive_byte(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_run(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      pace_sender();
      drive_byte(byte_t'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    int unsigned run_len;
    sorter_sb    = new();
    bytes_sent   = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data_byte = '0;
    in_is_last   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: single-byte runs at both extremes
    send_list('{8'h00});
    send_list('{8'hFF});
    // mixed order touching every bit
    send_list('{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE});
    idle_cycles(3);
    // repeated values
    send_list('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
    // already in order
    send_list('{8'h01, 8'h02, 8'h03});

    // store exactly full, then one past full so the last byte is dropped
    send_random_run(SORT_DEPTH);
    send_random_run(SORT_DEPTH + 1);

    // random runs, mostly short, now and then past capacity
    while (bytes_sent < 220) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0)
        run_len = $urandom_range(SORT_DEPTH - 2, SORT_DEPTH + 4);
      else
        run_len = $urandom_range(1, 12);
      send_random_run(run_len);
    end
    idle_cycles(1);

    // drain the last run and allow for stray output
    while (sorter_sb.pending() != 0) @(posedge clk);
    repeat (2 * SORT_DEPTH + 10) @(posedge clk);

    $display("covered %0d input transactions over %0d runs, %0d of them past capacity",
             bytes_sent, sorter_sb.runs_done, sorter_sb.overflow_runs);
    $display("checked %0d sorted bytes, %0d mismatches", sorter_sb.checked, sorter_sb.errors);
    if (sorter_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
